// ===== rtl/frustum_box_sphere_cull_core_defines.svh =====
// Assertion macros for the frustum cull checker.
`ifndef FRUSTUM_BOX_SPHERE_CULL_CORE_DEFINES_SVH
`define FRUSTUM_BOX_SPHERE_CULL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define FBSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fbsc check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define FBSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fbsc check failed");

`endif

// ===== rtl/fbsc_pkg.sv =====
// Types and constants for the frustum cull core.
`timescale 1ns / 1ps

package fbsc_pkg;

    localparam int COORD_W   = 16;  // Q12.4 point coordinate
    localparam int NORM_W    = 16;  // Q1.14 normal component
    localparam int RADIUS_W  = 15;  // Q11.4 unsigned radius
    localparam int PT_W      = 18;  // Q12.5 corner after center/size expansion
    localparam int PROD_W    = NORM_W + PT_W;
    localparam int ACC_W     = 37;  // three products plus distance and radius terms
    localparam int DIST_SH   = 15;  // Q12.4 * 2^15 lines up with Q1.14 * Q12.5
    localparam int CMD_W     = 2;
    localparam int PLANE_W   = 64;
    localparam int REG_IDX_W = 3;
    localparam int REJ_W     = 3;

    localparam logic [CMD_W-1:0] CMD_BOX_MINMAX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOX_CENTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPHERE     = 2'd2;

    localparam logic [REJ_W-1:0] VISIBLE_CODE = 3'd6;

    // Register layout: d in 63:48, nz in 47:32, ny in 31:16, nx in 15:0.
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [NORM_W-1:0]  nz;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nx;
    } plane_t;

    // Volume with corners in Q12.5, shared by all plane lanes.
    typedef struct packed {
        logic                       skip;    // unused command, no test
        logic                       sphere;
        logic [RADIUS_W-1:0]        radius;
        logic signed [PT_W-1:0]     lo_x;
        logic signed [PT_W-1:0]     lo_y;
        logic signed [PT_W-1:0]     lo_z;
        logic signed [PT_W-1:0]     hi_x;
        logic signed [PT_W-1:0]     hi_y;
        logic signed [PT_W-1:0]     hi_z;
    } vol_t;

endpackage

// ===== rtl/frustum_box_sphere_cull_core.sv =====
// Frustum cull core: tests one box or sphere per word against the frustum planes.
`timescale 1ns / 1ps

// Usage:
//  - Planes are loaded through cfg_we/cfg_addr/cfg_wdata, one 64-bit plane per
//    index (d, nz, ny, nx, 16 bits each). Write only while the core is idle.
//    Indexes at or beyond PLANE_COUNT are ignored.
//  - Input channel s_*: valid/ready. Command selects box by min/max, box by
//    center/size, or sphere by center/radius; command 3 always returns visible.
//  - Result channel m_*: valid/ready, one word per input word, in order.
//    m_visible = 1 and m_reject_plane = 6 when no plane rejects, else the
//    lowest rejecting plane index.
//  - The accepting edge loads the input register; the result register loads
//    and raises m_valid once the result side is free or being drained.
//  - Throughput: one word per cycle unless m_ready stalls. All plane lanes
//    run in parallel: corner select, one 16x18 multiply per axis, five-term add.
//  - When m_ready is low the result register holds and the input register
//    fills; s_ready drops only when both are full.
//  - Reset (aresetn low, synchronous) empties both stages and zeroes all
//    planes; an all-zero plane never rejects.

module frustum_box_sphere_cull_core #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  logic [fbsc_pkg::REG_IDX_W-1:0]        cfg_addr,
    input  logic [fbsc_pkg::PLANE_W-1:0]          cfg_wdata,
    // input word
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [fbsc_pkg::CMD_W-1:0]            s_command,
    input  logic signed [fbsc_pkg::COORD_W-1:0]   s_point_a_x,
    input  logic signed [fbsc_pkg::COORD_W-1:0]   s_point_a_y,
    input  logic signed [fbsc_pkg::COORD_W-1:0]   s_point_a_z,
    input  logic signed [fbsc_pkg::COORD_W-1:0]   s_point_b_x,
    input  logic signed [fbsc_pkg::COORD_W-1:0]   s_point_b_y,
    input  logic signed [fbsc_pkg::COORD_W-1:0]   s_point_b_z,
    input  logic [fbsc_pkg::RADIUS_W-1:0]         s_sphere_radius,
    // result word
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_visible,
    output logic [fbsc_pkg::REJ_W-1:0]            m_reject_plane
);

    // plane registers
    fbsc_pkg::plane_t plane_reg [PLANE_COUNT];

    // input stage
    logic                                 in_vld_reg, in_vld_next;
    logic [fbsc_pkg::CMD_W-1:0]           cmd_reg;
    logic signed [fbsc_pkg::COORD_W-1:0]  a_x_reg, a_y_reg, a_z_reg;
    logic signed [fbsc_pkg::COORD_W-1:0]  b_x_reg, b_y_reg, b_z_reg;
    logic [fbsc_pkg::RADIUS_W-1:0]        radius_reg;

    // result stage
    logic                                 m_valid_reg, m_valid_next;
    logic                                 visible_reg, visible_next;
    logic [fbsc_pkg::REJ_W-1:0]           rej_reg, rej_next;

    logic                                 advance, s_accept;
    fbsc_pkg::vol_t                       vol;
    logic [PLANE_COUNT-1:0]               reject;

    // Whole pipe moves when the result register is free or being drained.
    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = !in_vld_reg || advance;
    assign s_accept = s_valid && s_ready;

    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                plane_reg[i] <= '0;
            end else if (cfg_we && cfg_addr == fbsc_pkg::REG_IDX_W'(i)) begin
                plane_reg[i] <= cfg_wdata;
            end
        end

        fbsc_plane_lane u_lane (
            .plane  (plane_reg[i]),
            .vol    (vol),
            .reject (reject[i])
        );
    end

    fbsc_volume_prep u_prep (
        .command (cmd_reg),
        .a_x     (a_x_reg),
        .a_y     (a_y_reg),
        .a_z     (a_z_reg),
        .b_x     (b_x_reg),
        .b_y     (b_y_reg),
        .b_z     (b_z_reg),
        .radius  (radius_reg),
        .vol     (vol)
    );

    // Lowest rejecting plane wins.
    always_comb begin
        rej_next = fbsc_pkg::VISIBLE_CODE;
        for (int i = PLANE_COUNT - 1; i >= 0; i--) begin
            if (reject[i]) begin
                rej_next = fbsc_pkg::REJ_W'(i);
            end
        end
        if (vol.skip) begin
            rej_next = fbsc_pkg::VISIBLE_CODE;
        end
        visible_next = (rej_next == fbsc_pkg::VISIBLE_CODE);
    end

    always_comb begin
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
        m_valid_next = advance ? in_vld_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg    <= s_command;
            a_x_reg    <= s_point_a_x;
            a_y_reg    <= s_point_a_y;
            a_z_reg    <= s_point_a_z;
            b_x_reg    <= s_point_b_x;
            b_y_reg    <= s_point_b_y;
            b_z_reg    <= s_point_b_z;
            radius_reg <= s_sphere_radius;
        end
        if (advance && in_vld_reg) begin
            visible_reg <= visible_next;
            rej_reg     <= rej_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_visible      = visible_reg;
    assign m_reject_plane = rej_reg;

endmodule

// ===== rtl/fbsc_volume_prep.sv =====
// Expands the input word into low/high corners in Q12.5.
`timescale 1ns / 1ps

module fbsc_volume_prep (
    input  logic [fbsc_pkg::CMD_W-1:0]           command,
    input  logic signed [fbsc_pkg::COORD_W-1:0]  a_x,
    input  logic signed [fbsc_pkg::COORD_W-1:0]  a_y,
    input  logic signed [fbsc_pkg::COORD_W-1:0]  a_z,
    input  logic signed [fbsc_pkg::COORD_W-1:0]  b_x,
    input  logic signed [fbsc_pkg::COORD_W-1:0]  b_y,
    input  logic signed [fbsc_pkg::COORD_W-1:0]  b_z,
    input  logic [fbsc_pkg::RADIUS_W-1:0]        radius,
    output fbsc_pkg::vol_t                       vol
);

    logic signed [fbsc_pkg::PT_W-1:0] a2_x, a2_y, a2_z;
    logic signed [fbsc_pkg::PT_W-1:0] bw_x, bw_y, bw_z;

    // Doubling a Q12.4 value gives the same number in Q12.5.
    assign a2_x = fbsc_pkg::PT_W'(a_x) <<< 1;
    assign a2_y = fbsc_pkg::PT_W'(a_y) <<< 1;
    assign a2_z = fbsc_pkg::PT_W'(a_z) <<< 1;
    assign bw_x = fbsc_pkg::PT_W'(b_x);
    assign bw_y = fbsc_pkg::PT_W'(b_y);
    assign bw_z = fbsc_pkg::PT_W'(b_z);

    always_comb begin
        vol.radius = radius;
        vol.sphere = 1'b0;
        vol.skip   = 1'b0;
        case (command)
            fbsc_pkg::CMD_BOX_MINMAX: begin
                vol.lo_x = a2_x;
                vol.lo_y = a2_y;
                vol.lo_z = a2_z;
                vol.hi_x = bw_x <<< 1;
                vol.hi_y = bw_y <<< 1;
                vol.hi_z = bw_z <<< 1;
            end
            fbsc_pkg::CMD_BOX_CENTER: begin
                // center +/- half size, exact with the extra fraction bit
                vol.lo_x = a2_x - bw_x;
                vol.lo_y = a2_y - bw_y;
                vol.lo_z = a2_z - bw_z;
                vol.hi_x = a2_x + bw_x;
                vol.hi_y = a2_y + bw_y;
                vol.hi_z = a2_z + bw_z;
            end
            fbsc_pkg::CMD_SPHERE: begin
                vol.sphere = 1'b1;
                vol.lo_x   = a2_x;
                vol.lo_y   = a2_y;
                vol.lo_z   = a2_z;
                vol.hi_x   = a2_x;
                vol.hi_y   = a2_y;
                vol.hi_z   = a2_z;
            end
            default: begin
                vol.skip = 1'b1;
                vol.lo_x = a2_x;
                vol.lo_y = a2_y;
                vol.lo_z = a2_z;
                vol.hi_x = a2_x;
                vol.hi_y = a2_y;
                vol.hi_z = a2_z;
            end
        endcase
    end

endmodule

// ===== rtl/fbsc_plane_lane.sv =====
// One plane test: positive-vertex dot product plus distance, sign check.
`timescale 1ns / 1ps

module fbsc_plane_lane (
    input  fbsc_pkg::plane_t plane,
    input  fbsc_pkg::vol_t   vol,
    output logic             reject
);

    logic signed [fbsc_pkg::NORM_W-1:0]  nx, ny, nz;
    logic signed [fbsc_pkg::COORD_W-1:0] d;
    logic signed [fbsc_pkg::PT_W-1:0]    px, py, pz;
    logic signed [fbsc_pkg::PROD_W-1:0]  prod_x, prod_y, prod_z;
    logic signed [fbsc_pkg::ACC_W-1:0]   dist_term, rad_term, acc;

    assign nx = plane.nx;
    assign ny = plane.ny;
    assign nz = plane.nz;
    assign d  = plane.d;

    // Max corner where the normal is non-negative; sphere has lo == hi.
    assign px = nx[fbsc_pkg::NORM_W-1] ? vol.lo_x : vol.hi_x;
    assign py = ny[fbsc_pkg::NORM_W-1] ? vol.lo_y : vol.hi_y;
    assign pz = nz[fbsc_pkg::NORM_W-1] ? vol.lo_z : vol.hi_z;

    assign prod_x = nx * px;
    assign prod_y = ny * py;
    assign prod_z = nz * pz;

    assign dist_term = fbsc_pkg::ACC_W'(d) <<< fbsc_pkg::DIST_SH;
    assign rad_term  = vol.sphere ?
                       (fbsc_pkg::ACC_W'(vol.radius) << fbsc_pkg::DIST_SH) : '0;

    // n.p + d + r < 0 means outside this plane
    assign acc = fbsc_pkg::ACC_W'(prod_x) + fbsc_pkg::ACC_W'(prod_y)
               + fbsc_pkg::ACC_W'(prod_z) + dist_term + rad_term;

    assign reject = acc[fbsc_pkg::ACC_W-1];

endmodule

// ===== rtl/fbsc_checker.sv =====
// Port-level checks for the frustum cull core, bound to the top level.
`timescale 1ns / 1ps
`include "frustum_box_sphere_cull_core_defines.svh"

module fbsc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_visible,
    input logic [fbsc_pkg::REJ_W-1:0]   m_reject_plane
);

    // visible words carry the no-reject code
    `FBSC_ASSERT_IMP(a_visible_code, m_valid && m_visible,
        m_reject_plane == fbsc_pkg::VISIBLE_CODE)

    // culled words name a real plane
    `FBSC_ASSERT_IMP(a_culled_plane, m_valid && !m_visible,
        m_reject_plane < fbsc_pkg::VISIBLE_CODE)

    // input backs up only when the result side is full and stalled
    `FBSC_ASSERT_IMP(a_backpressure, !s_ready, m_valid && !m_ready)

    // stalled result holds
    `FBSC_ASSERT_NXT(a_hold, m_valid && !m_ready,
        m_valid && $stable(m_visible) && $stable(m_reject_plane))

endmodule

bind frustum_box_sphere_cull_core fbsc_checker u_fbsc_checker (.*);
